// ===== src/deq_pkg.sv =====
// Shared types, constants and index helpers for the double-ended queue.
// Used by the top level, deq_outbuf and the bench, but not by deq_ram; depends on nothing.
`default_nettype none
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LIST_FWD   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LIST_BWD   = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic [STAT_W-1:0] status;
    logic              last;
  } result_t;

  // (a + b) mod DEPTH for a, b below DEPTH
  function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/double_ended_queue_unit.sv =====
// Top level of the double-ended queue: front/occupancy control, ring RAM, output register.
// Depends on deq_pkg, deq_ram and deq_outbuf.
//
//   port group  dir  tdata        tuser       tlast
//   s_*         in   value[31:0]  mode[2:0]   -
//   m_*         out  word[31:0]   status[1:0] end of the results of one input word
//
// A push, a full push, or a pop/list on an empty queue writes its result straight to the output register.
// A pop first reads the ring RAM, whose read data is registered, then passes the word to the output register.
// A listing reads its entries in turn, one entry per cycle after the first read while the output register is ready.
// Reset clears sequencer state, front index, occupancy and output valid; RAM contents are left as they are.
// A stall on the master port holds the sequencer; new input words wait meanwhile.
`default_nettype none
module double_ended_queue_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_tvalid_i,
  output      logic                       s_tready_o,
  input  wire logic [deq_pkg::DATA_W-1:0] s_tdata_i,  // value
  input  wire logic [deq_pkg::MODE_W-1:0] s_tuser_i,  // mode
  output      logic                       m_tvalid_o,
  input  wire logic                       m_tready_i,
  output      logic [deq_pkg::DATA_W-1:0] m_tdata_o,  // word
  output      logic [deq_pkg::STAT_W-1:0] m_tuser_o,  // status
  output      logic                       m_tlast_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                      st_q, st_d;
  logic [deq_pkg::IDX_W-1:0] front_q, front_d;
  logic [deq_pkg::CNT_W-1:0] occ_q, occ_d;
  logic [deq_pkg::IDX_W-1:0] off_q, off_d;
  logic [deq_pkg::CNT_W-1:0] rem_q, rem_d;
  logic                      fwd_q, fwd_d;

  logic                       we, re;
  logic [deq_pkg::IDX_W-1:0]  waddr, raddr;
  logic [deq_pkg::DATA_W-1:0] rdata;
  logic                       ob_push, ob_ready;
  deq_pkg::result_t           res;
  logic                       in_acc, full, empty;
  logic [deq_pkg::IDX_W-1:0]  occm1;

  assign s_tready_o = (st_q == S_IDLE) && ob_ready;
  assign in_acc     = s_tvalid_i && s_tready_o;
  assign full       = (occ_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign empty      = (occ_q == '0);
  assign occm1      = deq_pkg::IDX_W'(occ_q - deq_pkg::CNT_W'(1));

  always_comb begin
    st_d       = st_q;
    front_d    = front_q;
    occ_d      = occ_q;
    off_d      = off_q;
    rem_d      = rem_q;
    fwd_d      = fwd_q;
    we         = 1'b0;
    waddr      = front_q;
    re         = 1'b0;
    raddr      = front_q;
    ob_push    = 1'b0;
    res.word   = '0;
    res.status = deq_pkg::STAT_OK;
    res.last   = 1'b1;

    if (st_q == S_IDLE) begin
      if (in_acc) begin
        case (s_tuser_i)
          deq_pkg::MODE_PUSH_BACK, deq_pkg::MODE_PUSH_FRONT: begin
            ob_push = 1'b1;
            if (full) begin
              res.status = deq_pkg::STAT_FULL;
            end else begin
              we    = 1'b1;
              occ_d = occ_q + deq_pkg::CNT_W'(1);
              if (s_tuser_i == deq_pkg::MODE_PUSH_BACK) begin
                waddr = deq_pkg::mod_add(front_q, occ_q[deq_pkg::IDX_W-1:0]);
              end else begin
                front_d = deq_pkg::mod_add(front_q,
                                           deq_pkg::IDX_W'(deq_pkg::DEPTH - 1));
                waddr   = front_d;
              end
            end
          end
          deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK: begin
            if (empty) begin
              ob_push    = 1'b1;
              res.status = deq_pkg::STAT_EMPTY;
            end else begin
              re    = 1'b1;
              occ_d = occ_q - deq_pkg::CNT_W'(1);
              rem_d = deq_pkg::CNT_W'(1);
              st_d  = S_READ;
              if (s_tuser_i == deq_pkg::MODE_POP_FRONT) begin
                raddr   = front_q;
                front_d = deq_pkg::mod_add(front_q, deq_pkg::IDX_W'(1));
              end else begin
                raddr = deq_pkg::mod_add(front_q, occm1);
              end
            end
          end
          deq_pkg::MODE_LIST_FWD, deq_pkg::MODE_LIST_BWD: begin
            if (empty) begin
              ob_push    = 1'b1;
              res.status = deq_pkg::STAT_EMPTY;
            end else begin
              fwd_d = (s_tuser_i == deq_pkg::MODE_LIST_FWD);
              off_d = fwd_d ? '0 : occm1;
              re    = 1'b1;
              raddr = deq_pkg::mod_add(front_q, off_d);
              rem_d = occ_q;
              st_d  = S_READ;
            end
          end
          default: begin
          end
        endcase
      end
    end else begin
      if (ob_ready) begin
        ob_push  = 1'b1;
        res.word = rdata;
        res.last = (rem_q == deq_pkg::CNT_W'(1));
        if (res.last) begin
          st_d = S_IDLE;
        end else begin
          off_d = fwd_q ? off_q + deq_pkg::IDX_W'(1) : off_q - deq_pkg::IDX_W'(1);
          re    = 1'b1;
          raddr = deq_pkg::mod_add(front_q, off_d);
          rem_d = rem_q - deq_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      front_q <= '0;
      occ_q   <= '0;
      off_q   <= '0;
      rem_q   <= '0;
      fwd_q   <= 1'b0;
    end else begin
      st_q    <= st_d;
      front_q <= front_d;
      occ_q   <= occ_d;
      off_q   <= off_d;
      rem_q   <= rem_d;
      fwd_q   <= fwd_d;
    end
  end

  deq_ram #(
    .WIDTH(deq_pkg::DATA_W),
    .DEPTH(deq_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(s_tdata_i),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  deq_outbuf u_outbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (ob_push),
    .res_i     (res),
    .ready_o   (ob_ready),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tuser_o (m_tuser_o),
    .m_tlast_o (m_tlast_o)
  );

endmodule
`default_nettype wire

// ===== src/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/deq_outbuf.sv =====
// One-word output register between the queue control and the master port.
// Depends on deq_pkg for the result word layout.
`default_nettype none
module deq_outbuf (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire deq_pkg::result_t           res_i,
  output      logic                       ready_o,
  output      logic                       m_tvalid_o,
  input  wire logic                       m_tready_i,
  output      logic [deq_pkg::DATA_W-1:0] m_tdata_o,  // word
  output      logic [deq_pkg::STAT_W-1:0] m_tuser_o,  // status
  output      logic                       m_tlast_o
);

  logic             valid_q;
  deq_pkg::result_t res_q;

  assign ready_o = !valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && push_i) begin
      res_q <= res_i;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = res_q.word;
  assign m_tuser_o  = res_q.status;
  assign m_tlast_o  = res_q.last;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for double_ended_queue_unit: a directed table, then biased random
// push/pop/list traffic, every result checked against the table or an in-bench deque predictor.
// Depends on deq_pkg and the RTL under src.
`default_nettype none
module tb_top;

  localparam logic [deq_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [deq_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;
  localparam int RANDOM_WORDS = 330;
  localparam int CALM_WORDS   = 60;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ROWS         = 19;

  typedef struct {
    logic [deq_pkg::MODE_W-1:0] mode;
    logic [deq_pkg::DATA_W-1:0] value;
    int                         reps;
    bit                         typed;
    deq_pkg::result_t           res;
  } stim_row_t;

  logic                       clk_i      = 1'b0;
  logic                       rst_ni     = 1'b0;
  logic                       s_tvalid_i = 1'b0;
  logic                       s_tready_o;
  logic [deq_pkg::DATA_W-1:0] s_tdata_i  = '0;  // value
  logic [deq_pkg::MODE_W-1:0] s_tuser_i  = '0;  // mode
  logic                       m_tvalid_o;
  logic                       m_tready_i = 1'b0;
  logic [deq_pkg::DATA_W-1:0] m_tdata_o;        // word
  logic [deq_pkg::STAT_W-1:0] m_tuser_o;        // status
  logic                       m_tlast_o;

  // predictor state
  logic [deq_pkg::DATA_W-1:0] ring_words [deq_pkg::DEPTH];
  int                         head_slot = 0;
  int                         stored    = 0;
  deq_pkg::result_t           awaited_results [$];

  int  fails       = 0;
  int  cycle_count = 0;
  bit  calm        = 1'b0;

  stim_row_t script [ROWS] = '{
    '{deq_pkg::MODE_POP_FRONT,  32'h0000_0000, 1, 1'b1,
      '{32'h0, deq_pkg::STAT_EMPTY, 1'b1}},
    '{deq_pkg::MODE_POP_BACK,   32'hFFFF_FFFF, 1, 1'b1,
      '{32'h0, deq_pkg::STAT_EMPTY, 1'b1}},
    '{deq_pkg::MODE_LIST_FWD,   32'h0000_0000, 1, 1'b1,
      '{32'h0, deq_pkg::STAT_EMPTY, 1'b1}},
    '{deq_pkg::MODE_LIST_BWD,   32'hFFFF_FFFF, 1, 1'b1,
      '{32'h0, deq_pkg::STAT_EMPTY, 1'b1}},
    '{MODE_SPARE_6,             32'hFFFF_FFFF, 1, 1'b0,
      '{32'h0, deq_pkg::STAT_OK, 1'b0}},
    '{MODE_SPARE_7,             32'h0000_0000, 1, 1'b0,
      '{32'h0, deq_pkg::STAT_OK, 1'b0}},
    '{deq_pkg::MODE_PUSH_BACK,  32'h7FFF_FFFF, 1, 1'b1,
      '{32'h0, deq_pkg::STAT_OK, 1'b1}},
    '{deq_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 1, 1'b1,
      '{32'h0, deq_pkg::STAT_OK, 1'b1}},
    '{deq_pkg::MODE_LIST_FWD,   32'h0000_0000, 1, 1'b0,
      '{32'h0, deq_pkg::STAT_OK, 1'b0}},
    '{deq_pkg::MODE_LIST_BWD,   32'h0000_0000, 1, 1'b0,
      '{32'h0, deq_pkg::STAT_OK, 1'b0}},
    '{deq_pkg::MODE_POP_FRONT,  32'hFFFF_FFFF, 1, 1'b1,
      '{32'h8000_0000, deq_pkg::STAT_OK, 1'b1}},
    '{deq_pkg::MODE_POP_BACK,   32'h0000_0000, 1, 1'b1,
      '{32'h7FFF_FFFF, deq_pkg::STAT_OK, 1'b1}},
    '{deq_pkg::MODE_LIST_FWD,   32'h0000_0000, 1, 1'b1,
      '{32'h0, deq_pkg::STAT_EMPTY, 1'b1}},
    '{deq_pkg::MODE_PUSH_FRONT, 32'hA5A5_0000, 8, 1'b0,
      '{32'h0, deq_pkg::STAT_OK, 1'b0}},
    '{deq_pkg::MODE_PUSH_BACK,  32'h5A5A_FFF0, 8, 1'b0,
      '{32'h0, deq_pkg::STAT_OK, 1'b0}},
    '{deq_pkg::MODE_PUSH_BACK,  32'h1234_5678, 1, 1'b1,
      '{32'h0, deq_pkg::STAT_FULL, 1'b1}},
    '{deq_pkg::MODE_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1'b1,
      '{32'h0, deq_pkg::STAT_FULL, 1'b1}},
    '{deq_pkg::MODE_LIST_FWD,   32'h0000_0000, 1, 1'b0,
      '{32'h0, deq_pkg::STAT_OK, 1'b0}},
    '{deq_pkg::MODE_LIST_BWD,   32'h0000_0000, 1, 1'b0,
      '{32'h0, deq_pkg::STAT_OK, 1'b0}}
  };

  double_ended_queue_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("double_ended_queue_unit verification failed");
      $finish;
    end
  end

  // Updates the deque image and queues the words the block must return.
  function automatic void apply_deque_op(input logic [deq_pkg::MODE_W-1:0] mode,
                                         input logic [deq_pkg::DATA_W-1:0] value,
                                         input bit typed,
                                         input deq_pkg::result_t typed_res);
    deq_pkg::result_t outs [$];
    deq_pkg::result_t r;
    int               off;
    r = '{word: '0, status: deq_pkg::STAT_OK, last: 1'b1};
    case (mode)
      deq_pkg::MODE_PUSH_BACK, deq_pkg::MODE_PUSH_FRONT: begin
        if (stored >= deq_pkg::DEPTH) begin
          r.status = deq_pkg::STAT_FULL;
        end else if (mode == deq_pkg::MODE_PUSH_BACK) begin
          ring_words[(head_slot + stored) % deq_pkg::DEPTH] = value;
          stored++;
        end else begin
          head_slot = (head_slot + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
          ring_words[head_slot] = value;
          stored++;
        end
        outs.push_back(r);
      end
      deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK: begin
        if (stored == 0) begin
          r.status = deq_pkg::STAT_EMPTY;
        end else if (mode == deq_pkg::MODE_POP_FRONT) begin
          r.word = ring_words[head_slot];
          head_slot = (head_slot + 1) % deq_pkg::DEPTH;
          stored--;
        end else begin
          r.word = ring_words[(head_slot + stored - 1) % deq_pkg::DEPTH];
          stored--;
        end
        outs.push_back(r);
      end
      deq_pkg::MODE_LIST_FWD, deq_pkg::MODE_LIST_BWD: begin
        if (stored == 0) begin
          r.status = deq_pkg::STAT_EMPTY;
          outs.push_back(r);
        end else begin
          for (int i = 0; i < stored; i++) begin
            off = (mode == deq_pkg::MODE_LIST_FWD) ? i : stored - 1 - i;
            r.word = ring_words[(head_slot + off) % deq_pkg::DEPTH];
            r.last = (i == stored - 1);
            outs.push_back(r);
          end
        end
      end
      default: ;
    endcase
    if (typed) begin
      awaited_results.push_back(typed_res);
    end else begin
      foreach (outs[k]) awaited_results.push_back(outs[k]);
    end
  endfunction

  task automatic issue(input logic [deq_pkg::MODE_W-1:0] mode,
                       input logic [deq_pkg::DATA_W-1:0] value,
                       input bit typed, input deq_pkg::result_t typed_res);
    int gap;
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= mode;
    s_tdata_i  <= value;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    apply_deque_op(mode, value, typed, typed_res);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid_i <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [deq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    deq_pkg::result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected word: word %h status %0d last %0b",
               m_tdata_o, m_tuser_o, m_tlast_o);
        fails++;
      end else begin
        want = awaited_results.pop_front();
        if (m_tdata_o !== want.word) begin
          $error("word: expected %h, actual %h", want.word, m_tdata_o);
          fails++;
        end
        if (m_tuser_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tuser_o);
          fails++;
        end
        if (m_tlast_o !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, m_tlast_o);
          fails++;
        end
      end
    end
  end

  initial begin : sink_pacing
    int n;
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready_i <= 1'b0;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      n = $urandom_range(1, 30);
      repeat (n) @(posedge clk_i);
    end
  end

  initial begin : source
    int                         counted;
    int                         r;
    bit                         filling;
    logic [deq_pkg::MODE_W-1:0] mode;
    counted = 0;
    filling = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      for (int k = 0; k < script[i].reps; k++) begin
        issue(script[i].mode, script[i].value + deq_pkg::DATA_W'(k), script[i].typed,
              script[i].res);
      end
    end
    drain();

    while (counted < RANDOM_WORDS) begin
      if (counted == RANDOM_WORDS / 2) begin
        drain();
      end
      calm = (counted >= RANDOM_WORDS - CALM_WORDS);
      if (stored == deq_pkg::DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
      if (stored == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
      if ($urandom_range(0, 24) == 0) filling = !filling;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        mode = $urandom_range(0, 1) ? MODE_SPARE_7 : MODE_SPARE_6;
      end else if (r < 12) begin
        mode = $urandom_range(0, 1) ? deq_pkg::MODE_LIST_BWD : deq_pkg::MODE_LIST_FWD;
        counted++;
      end else if (($urandom_range(0, 9) < 7) == filling) begin
        mode = $urandom_range(0, 1) ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_PUSH_BACK;
        counted++;
      end else begin
        mode = $urandom_range(0, 1) ? deq_pkg::MODE_POP_BACK : deq_pkg::MODE_POP_FRONT;
        counted++;
      end
      issue(mode, pick_value(), 1'b0, '0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("double_ended_queue_unit verification clean");
    end else begin
      $display("double_ended_queue_unit verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
